// ===== hw/rtl/i2a_pkg.sv =====
// Shared types, constants and character helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned FifoDepthDef = 2;
  localparam int unsigned DecBits      = 32;
  localparam int unsigned BcdDigits    = 10;
  localparam int unsigned HexDigits    = 16;
  localparam int unsigned NilLen       = 5;
  localparam int unsigned PrefixLen    = 2;

  typedef enum logic [1:0] {
    CMD_PTR    = 2'd0,
    CMD_HEX_LO = 2'd1,
    CMD_HEX_UP = 2'd2,
    CMD_DEC    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [63:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [4:0] char_count;
  } out_rsp_t;

  // One classified request waiting for the emitter: digits are right aligned,
  // least significant digit in nibble 0.
  typedef struct packed {
    cmd_e        cmd;
    logic        is_nil;
    logic [4:0]  len;
    logic [63:0] digits;
  } entry_t;

  function automatic logic [7:0] nil_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h28; // (
      3'd1:    c = 8'h6e; // n
      3'd2:    c = 8'h69; // i
      3'd3:    c = 8'h6c; // l
      default: c = 8'h29; // )
    endcase
    return c;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else if (upper) begin
      c = 8'h37 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/i2a_front.sv =====
// Front end: accepts requests, converts decimal by shift-add-3, counts digits.
`timescale 1ns / 1ps

module i2a_front #(
  parameter int unsigned ValueBits = i2a_pkg::ValueBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2a_pkg::in_req_t  in_req_i,
  output logic              push_o,
  output i2a_pkg::entry_t   push_entry_o,
  input  logic              full_i
);
  import i2a_pkg::*;

  localparam logic [63:0] ValueMask =
    (ValueBits >= 64) ? {64{1'b1}} : ((64'd1 << ValueBits) - 64'd1);
  localparam int unsigned BcdBits = 4 * BcdDigits;

  fe_state_e   state_q, state_d;
  cmd_e        cmd_q, cmd_d;
  logic [63:0] work_q, work_d;
  logic [31:0] bin_q, bin_d;
  logic [4:0]  bit_cnt_q, bit_cnt_d;

  logic [BcdBits-1:0] adj;
  logic [3:0]         hi_idx;
  logic [4:0]         ndig;
  logic               is_nil;
  logic [4:0]         len;

  // shift-add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[4*i +: 4] = (work_q[4*i +: 4] >= 4'd5) ? work_q[4*i +: 4] + 4'd3
                                                  : work_q[4*i +: 4];
    end
  end

  // highest nonzero digit sets the digit count
  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < HexDigits; i++) begin
      if (work_q[4*i +: 4] != 4'd0) begin
        hi_idx = 4'(i);
      end
    end
    ndig   = {1'b0, hi_idx} + 5'd1;
    is_nil = (cmd_q == CMD_PTR) && (work_q == 64'd0);
    if (is_nil) begin
      len = 5'(NilLen);
    end else if (cmd_q == CMD_PTR) begin
      len = ndig + 5'(PrefixLen);
    end else begin
      len = ndig;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    work_d     = work_q;
    bin_d      = bin_q;
    bit_cnt_d  = bit_cnt_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      FE_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_req_i.command;
          if (in_req_i.command == CMD_DEC) begin
            work_d    = '0;
            bin_d     = in_req_i.value[31:0];
            bit_cnt_d = '0;
            state_d   = FE_CONV;
          end else begin
            work_d  = in_req_i.value & ValueMask;
            state_d = FE_PUSH;
          end
        end
      end
      FE_CONV: begin
        work_d    = {{(64-BcdBits){1'b0}}, adj[BcdBits-2:0], bin_q[31]};
        bin_d     = {bin_q[30:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 5'd1;
        if (bit_cnt_q == 5'(DecBits - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  assign push_entry_o = '{cmd: cmd_q, is_nil: is_nil, len: len, digits: work_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FE_IDLE;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    work_q <= work_d;
    bin_q  <= bin_d;
  end

endmodule

// ===== hw/rtl/i2a_fifo.sv =====
// Short request queue between the front end and the character emitter.
`timescale 1ns / 1ps

module i2a_fifo #(
  parameter int unsigned Depth = i2a_pkg::FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2a_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output i2a_pkg::entry_t head_o
);
  import i2a_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("request queue overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("request queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("request queue count out of range");
`endif

endmodule

// ===== hw/rtl/i2a_back.sv =====
// Back end: walks one queued request and emits its characters one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module i2a_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ent_valid_i,
  input  i2a_pkg::entry_t   ent_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2a_pkg::out_rsp_t out_rsp_o
);
  import i2a_pkg::*;

  logic     busy_q;
  entry_t   ent_q;
  logic [4:0] pos_q;
  logic     out_valid_q;
  out_rsp_t out_q;

  logic       can_emit;
  logic       is_last;
  logic [4:0] dig_idx;
  logic [3:0] nibble;
  logic [7:0] chr;

  assign can_emit = busy_q && (!out_valid_q || out_ready_i);
  assign is_last  = (pos_q == ent_q.len - 5'd1);
  assign pop_o    = ent_valid_i && (!busy_q || (can_emit && is_last));

  // digits fill the tail of the run, most significant first
  assign dig_idx = ent_q.len - 5'd1 - pos_q;
  assign nibble  = ent_q.digits[{dig_idx[3:0], 2'b00} +: 4];

  always_comb begin
    if (ent_q.is_nil) begin
      chr = nil_char(pos_q[2:0]);
    end else if (ent_q.cmd == CMD_PTR && pos_q == 5'd0) begin
      chr = 8'h30;
    end else if (ent_q.cmd == CMD_PTR && pos_q == 5'd1) begin
      chr = 8'h78;
    end else begin
      chr = digit_char(nibble, ent_q.cmd == CMD_HEX_UP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (can_emit) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= ent_i;
    end
    if (can_emit) begin
      out_q <= '{character: chr, last: is_last,
                 char_count: is_last ? ent_q.len : 5'd0};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.last |-> out_rsp_o.char_count != 5'd0)
    else $error("last character without a count");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q < ent_q.len) else $error("character position past run");
`endif

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, queue, emitter.
`timescale 1ns / 1ps
// Path: front end, queue, then the registered emitter output; decimal requests are converted first.
// Throughput: the emitter sends one character per cycle while out_ready_i is high, so its time
//   per request follows the run length (1 to 18 characters); the front end takes one request at a
//   time, decimal ones through 32 shift-add-3 steps, so the slower of the two sets the rate.
// Reset: asynchronous active low; clears the queue, both state machines, output valid.

module integer_to_ascii_formatter #(
  parameter int unsigned ValueBits = i2a_pkg::ValueBitsDef,
  parameter int unsigned FifoDepth = i2a_pkg::FifoDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2a_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2a_pkg::out_rsp_t out_rsp_o
);
  import i2a_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  i2a_front #(.ValueBits(ValueBits)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  i2a_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (head_valid),
    .head_o       (head)
  );

  i2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (head_valid),
    .ent_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
